// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a consequent in the same cycle as its antecedent
`define TBR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// check a consequent in the cycle after its antecedent
`define TBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/tbr_pkg.sv
`default_nettype none

package tbr_pkg;

  localparam int COORD_BITS    = 24;
  localparam int CORDIC_STAGES = 20;

  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int MAG_BITS      = COORD_BITS;
  localparam int SQ_BITS       = 2 * MAG_BITS;
  localparam int ROOT_BITS     = COORD_BITS + 1;
  localparam int SUM_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS      = ROOT_BITS + 2;
  localparam int CUR_BITS      = REM_BITS + 2;
  localparam int ROUND_BITS    = ROOT_BITS + 1;

  localparam int CORDIC_BITS   = 64;
  localparam int GUARD_SHIFT   = 60 - COORD_BITS;
  localparam int ANGLE_BITS    = 32;
  localparam int STEP_IDX_BITS = 5;

  localparam int BEARING_BITS  = 16;
  localparam int RANGE_BITS    = 25;
  localparam int PROD_BITS     = ANGLE_BITS + BEARING_BITS;
  localparam int CMP_BITS      = (ROUND_BITS > RANGE_BITS) ? ROUND_BITS : RANGE_BITS;

  localparam logic [RANGE_BITS-1:0]   RANGE_MAX     = '1;
  localparam logic [BEARING_BITS-1:0] CENTIDEG_TURN = 16'd36000;
  localparam logic [ANGLE_BITS-1:0]   HALF_TURN     = 32'h8000_0000;

  // pipeline stage map
  localparam int S_DIFF     = 0;
  localparam int S_PREP     = 1;
  localparam int S_SQUARE   = 2;
  localparam int S_SUM      = 3;
  localparam int SQRT_END   = S_SUM + ROOT_BITS;
  localparam int RANGE_DONE = SQRT_END + 1;
  localparam int CORD_END   = S_PREP + CORDIC_STAGES;
  localparam int S_SCALE    = CORD_END + 1;
  localparam int BEAR_DONE  = CORD_END + 2;
  localparam int LAST_STAGE = (BEAR_DONE > RANGE_DONE) ? BEAR_DONE : RANGE_DONE;

  // atan(2^-i) in binary angle, 2^32 = one turn
  localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
  } query_t;

  typedef struct packed {
    logic [BEARING_BITS-1:0] bearing_centideg;
    logic [RANGE_BITS-1:0]   range_dist;
    logic                    coincident;
  } result_t;

  typedef struct packed {
    logic signed [CORDIC_BITS-1:0] x;
    logic signed [CORDIC_BITS-1:0] y;
    logic [ANGLE_BITS-1:0]         z;
  } cordic_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_t;

endpackage

`default_nettype wire

// File: rtl/core/tbr_stream_if.sv
`default_nettype none

interface tbr_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tbr_cordic_step.sv
`default_nettype none

module tbr_cordic_step import tbr_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [STEP_IDX_BITS-1:0] idx,
  input  cordic_t                  din,
  output cordic_t                  dout
);

  logic signed [CORDIC_BITS-1:0] x_in;
  logic signed [CORDIC_BITS-1:0] y_in;
  logic signed [CORDIC_BITS-1:0] xs;
  logic signed [CORDIC_BITS-1:0] ys;
  logic signed [CORDIC_BITS-1:0] x_next;
  logic signed [CORDIC_BITS-1:0] y_next;
  logic [ANGLE_BITS-1:0]         z_next;

  always_comb begin
    x_in = din.x;
    y_in = din.y;
    xs   = x_in >>> idx;
    ys   = y_in >>> idx;
    // rotate toward the x axis; the angle wraps modulo one turn
    if (!y_in[CORDIC_BITS-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = din.z + ATAN_TURNS[idx];
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = din.z - ATAN_TURNS[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= '{x: x_next, y: y_next, z: z_next};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tbr_sqrt_step.sv
`default_nettype none

module tbr_sqrt_step import tbr_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  logic [CUR_BITS-1:0]  cur;
  logic [CUR_BITS-1:0]  trial;
  logic [REM_BITS-1:0]  rem_next;
  logic [ROOT_BITS-1:0] root_next;

  // one result bit per step: bring down two radicand bits, try 4*root+1
  always_comb begin
    cur   = {din.rem, din.rad[SUM_BITS-1 -: 2]};
    trial = CUR_BITS'({din.root, 2'b01});
    if (cur >= trial) begin
      rem_next  = REM_BITS'(cur - trial);
      root_next = {din.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_next  = REM_BITS'(cur);
      root_next = {din.root[ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= '{rad: {din.rad[SUM_BITS-3:0], 2'b00}, rem: rem_next, root: root_next};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tbr_bearing_scale.sv
`default_nettype none

module tbr_bearing_scale import tbr_pkg::*; (
  input  logic                    clk,
  input  logic                    en_mul,
  input  logic                    en_fold,
  input  logic [ANGLE_BITS-1:0]   angle,
  input  logic                    coincident,
  output logic [BEARING_BITS-1:0] bearing
);

  logic [PROD_BITS-1:0]    prod;
  logic [PROD_BITS-1:0]    prod_rnd;
  logic [BEARING_BITS-1:0] centideg;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod <= PROD_BITS'(angle) * PROD_BITS'(CENTIDEG_TURN);
    end
  end

  // round half up, then fold a full turn back to zero
  always_comb begin
    prod_rnd = prod + PROD_BITS'(HALF_TURN);
    centideg = prod_rnd[PROD_BITS-1 -: BEARING_BITS];
  end

  always_ff @(posedge clk) begin
    if (en_fold) begin
      if (coincident || (centideg >= CENTIDEG_TURN)) begin
        bearing <= '0;
      end else begin
        bearing <= centideg;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/target_bearing_and_range_top.sv
// Bearing and range from an origin point to a target point.
//
// query  (sink):   one word holds origin_x/y and target_x/y, signed Q15.8.
// result (source): bearing_centideg (clockwise from +Y, 0..35999),
//                  range_dist (unsigned Q.8, rounded to nearest) and
//                  coincident (points equal; bearing and range are then 0).
// Both channels move a word when valid and ready are high at a clock edge.
//
// Pipeline: 30 stages, set by the 25-step square root; the 20-step
// CORDIC and the bearing scaling run beside it.
// Throughput: one word per cycle while result.ready is high.
//
// Reset (rst, synchronous) empties the pipeline; no results are pending.
// When result.ready is low, the last stage holds its word and the words
// behind it close up any empty stages. query.ready falls only when all
// stages hold a word and the output is not taken.
`default_nettype none
`include "assert_macros.svh"

module target_bearing_and_range_top import tbr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tbr_stream_if.sink   query,
  tbr_stream_if.source result
);

  logic [LAST_STAGE:0]   stage_valid;
  logic [LAST_STAGE+1:0] en;

  logic signed [DIFF_BITS-1:0] east;
  logic signed [DIFF_BITS-1:0] north;

  logic                coinc [S_PREP:LAST_STAGE];
  logic [MAG_BITS-1:0] mag_e;
  logic [MAG_BITS-1:0] mag_n;
  logic [SQ_BITS-1:0]  sq_e;
  logic [SQ_BITS-1:0]  sq_n;

  cordic_t cd [S_PREP:CORD_END];
  sqrt_t   sr [S_SUM:SQRT_END];

  logic [BEARING_BITS-1:0] bear [BEAR_DONE:LAST_STAGE];
  logic [RANGE_BITS-1:0]   rng  [RANGE_DONE:LAST_STAGE];

  logic signed [CORDIC_BITS-1:0] x_scaled;
  logic signed [CORDIC_BITS-1:0] y_scaled;
  cordic_t                       cd_init;
  logic [ROUND_BITS-1:0]         rounded;

  // ---------------------------------------------------------------- control
  assign en[LAST_STAGE+1] = result.ready;

  for (genvar k = 0; k <= LAST_STAGE; k++) begin : g_en
    assign en[k] = !stage_valid[k] || en[k+1];
  end

  assign query.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= query.valid;
      end
      for (int k = 1; k <= LAST_STAGE; k++) begin
        if (en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------- displacement
  always_ff @(posedge clk) begin
    if (en[S_DIFF]) begin
      east  <= DIFF_BITS'(query.word.target_x) - DIFF_BITS'(query.word.origin_x);
      north <= DIFF_BITS'(query.word.target_y) - DIFF_BITS'(query.word.origin_y);
    end
  end

  // ------------------------------------------------------------ prepare
  // rotate the southern half plane by half a turn so CORDIC converges
  always_comb begin
    x_scaled = CORDIC_BITS'(north) <<< GUARD_SHIFT;
    y_scaled = CORDIC_BITS'(east) <<< GUARD_SHIFT;
    if (north[DIFF_BITS-1]) begin
      cd_init = '{x: -x_scaled, y: -y_scaled, z: HALF_TURN};
    end else begin
      cd_init = '{x: x_scaled, y: y_scaled, z: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PREP]) begin
      coinc[S_PREP] <= (east == '0) && (north == '0);
      mag_e         <= east[DIFF_BITS-1] ? MAG_BITS'(-east) : MAG_BITS'(east);
      mag_n         <= north[DIFF_BITS-1] ? MAG_BITS'(-north) : MAG_BITS'(north);
      cd[S_PREP]    <= cd_init;
    end
  end

  for (genvar k = S_PREP + 1; k <= LAST_STAGE; k++) begin : g_coinc
    always_ff @(posedge clk) begin
      if (en[k]) begin
        coinc[k] <= coinc[k-1];
      end
    end
  end

  // -------------------------------------------------------------- range
  always_ff @(posedge clk) begin
    if (en[S_SQUARE]) begin
      sq_e <= mag_e * mag_e;
      sq_n <= mag_n * mag_n;
    end
    if (en[S_SUM]) begin
      sr[S_SUM] <= '{rad: SUM_BITS'(sq_e) + SUM_BITS'(sq_n), rem: '0, root: '0};
    end
  end

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
    tbr_sqrt_step u_step (
      .clk  (clk),
      .en   (en[S_SUM+1+i]),
      .din  (sr[S_SUM+i]),
      .dout (sr[S_SUM+1+i])
    );
  end

  // round to nearest: step up when the remainder exceeds the root
  always_comb begin
    rounded = ROUND_BITS'(sr[SQRT_END].root);
    if (sr[SQRT_END].rem > REM_BITS'(sr[SQRT_END].root)) begin
      rounded = rounded + ROUND_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[RANGE_DONE]) begin
      if (CMP_BITS'(rounded) > CMP_BITS'(RANGE_MAX)) begin
        rng[RANGE_DONE] <= RANGE_MAX;
      end else begin
        rng[RANGE_DONE] <= RANGE_BITS'(rounded);
      end
    end
  end

  for (genvar k = RANGE_DONE + 1; k <= LAST_STAGE; k++) begin : g_rng
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rng[k] <= rng[k-1];
      end
    end
  end

  // ------------------------------------------------------------ bearing
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    tbr_cordic_step u_step (
      .clk  (clk),
      .en   (en[S_PREP+1+i]),
      .idx  (STEP_IDX_BITS'(i)),
      .din  (cd[S_PREP+i]),
      .dout (cd[S_PREP+1+i])
    );
  end

  tbr_bearing_scale u_scale (
    .clk        (clk),
    .en_mul     (en[S_SCALE]),
    .en_fold    (en[BEAR_DONE]),
    .angle      (cd[CORD_END].z),
    .coincident (coinc[S_SCALE]),
    .bearing    (bear[BEAR_DONE])
  );

  for (genvar k = BEAR_DONE + 1; k <= LAST_STAGE; k++) begin : g_bear
    always_ff @(posedge clk) begin
      if (en[k]) begin
        bear[k] <= bear[k-1];
      end
    end
  end

  // ------------------------------------------------------------- output
  assign result.valid = stage_valid[LAST_STAGE];
  assign result.word  = '{bearing_centideg: bear[LAST_STAGE],
                          range_dist:       rng[LAST_STAGE],
                          coincident:       coinc[LAST_STAGE]};

  // ---------------------------------------------------------- assertions
  `TBR_ASSERT_NOW(a_coinc_zero, clk, rst, result.valid && result.word.coincident, (result.word.range_dist == '0) && (result.word.bearing_centideg == '0))
  `TBR_ASSERT_NOW(a_zero_range_coinc, clk, rst, result.valid && (result.word.range_dist == '0), result.word.coincident)
  `TBR_ASSERT_NOW(a_bearing_bound, clk, rst, result.valid, result.word.bearing_centideg < CENTIDEG_TURN)
  `TBR_ASSERT_NOW(a_stall_full, clk, rst, !query.ready, (&stage_valid) && !result.ready)
  `TBR_ASSERT_NEXT(a_same_point_diff, clk, rst, query.valid && query.ready && (query.word.target_x == query.word.origin_x) && (query.word.target_y == query.word.origin_y), (east == '0) && (north == '0))

endmodule

`default_nettype wire
